### rtl/core/tbrl_pkg.sv
// Package for the token bucket rate limiter: widths, register indexes, state and command types.
`timescale 1ns / 1ps
package tbrl_pkg;

   localparam int TICKS_W      = 16;
   localparam int TOKENS_OUT_W = 16;
   localparam int INTERVAL_W   = 32;
   localparam int BURST_W      = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;

   localparam int DEF_TIME_BITS  = 32;
   localparam int DEF_TOKEN_BITS = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_UNLIMITED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST     = 2'd2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;
   localparam logic [BURST_W-1:0]    BURST_RESET    = 16'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_REFILL,
      ST_TAKE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic refill;
      logic take;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic unlimited;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

### rtl/core/tbrl_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module tbrl_divider #(
   parameter int DIVIDEND_BITS = 32,
   parameter int DIVISOR_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS+1:0]  diff;
   logic                     borrow;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff    = {1'b0, trial} - {2'b00, divisor};
      borrow  = diff[DIVISOR_BITS+1];
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIVIDEND_BITS);
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = borrow ? trial[DIVISOR_BITS-1:0] : diff[DIVISOR_BITS-1:0];
         quo_in   = {quo_ff[DIVIDEND_BITS-2:0], ~borrow};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/tbrl_ctrl.sv
// Controller state machine that sequences accumulation, division, refill, take and result.
`timescale 1ns / 1ps
module tbrl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_ready,
   input  tbrl_pkg::status_type status,
   output tbrl_pkg::cmd_type   cmd
);
   import tbrl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode && !status.unlimited) state_in = ST_DIV_START;
               else                               state_in = ST_DONE;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_REFILL;
         end
         ST_REFILL: state_in = ST_TAKE;
         ST_TAKE:   state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_DIV_WAIT:  cmd           = '0;
         ST_REFILL:    cmd.refill    = 1'b1;
         ST_TAKE:      cmd.take      = 1'b1;
         ST_DONE:      cmd.load_rsp  = status.rsp_free;
         default:      cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/tbrl_datapath.sv
// Datapath: configuration registers, elapsed and token counters, divider and result register.
`timescale 1ns / 1ps
module tbrl_datapath #(
   parameter int TIME_BITS  = tbrl_pkg::DEF_TIME_BITS,
   parameter int TOKEN_BITS = tbrl_pkg::DEF_TOKEN_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbrl_pkg::cmd_type                     cmd,
   output tbrl_pkg::status_type                  status,
   input  logic                                  csr_write_enable,
   input  logic [tbrl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tbrl_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                  req_mode,
   input  logic [tbrl_pkg::TICKS_W-1:0]          req_ticks,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_granted,
   output logic [tbrl_pkg::TOKENS_OUT_W-1:0]     rsp_tokens_left
);
   import tbrl_pkg::*;

   localparam int SUM_W  = ((TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W) + 1;
   localparam int CAP_W  = (TOKEN_BITS > BURST_W) ? TOKEN_BITS : BURST_W;
   localparam int CMP_W  = (TIME_BITS > TOKEN_BITS) ? TIME_BITS : TOKEN_BITS;
   localparam int TOUT_W = (TOKEN_BITS > TOKENS_OUT_W) ? TOKEN_BITS : TOKENS_OUT_W;

   logic                    unlimited_ff, unlimited_in;
   logic [INTERVAL_W-1:0]   interval_ff, interval_in;
   logic [BURST_W-1:0]      burst_ff, burst_in;
   logic [TIME_BITS-1:0]    elapsed_ff, elapsed_in;
   logic [TOKEN_BITS-1:0]   token_ff, token_in;
   logic                    grant_ff, grant_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff;
   logic [TOKENS_OUT_W-1:0] rsp_tokens_ff;

   logic [SUM_W-1:0]        sum;
   logic [SUM_W-1:0]        time_max;
   logic [TIME_BITS-1:0]    elapsed_sat;
   logic [INTERVAL_W-1:0]   step;
   logic                    div_done;
   logic [TIME_BITS-1:0]    quotient;
   logic [CAP_W-1:0]        burst_ext;
   logic [CAP_W-1:0]        token_max;
   logic [CAP_W-1:0]        cap_ext;
   logic [TOKEN_BITS-1:0]   cap;
   logic [TOKEN_BITS-1:0]   room;
   logic [CMP_W-1:0]        quo_ext;
   logic [CMP_W-1:0]        room_ext;
   logic [TOKEN_BITS-1:0]   add;
   logic [TOUT_W-1:0]       token_out;
   logic                    csr_hit;

   tbrl_divider #(
      .DIVIDEND_BITS (TIME_BITS),
      .DIVISOR_BITS  (INTERVAL_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (elapsed_ff),
      .divisor  (step),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      sum         = SUM_W'(elapsed_ff) + SUM_W'(req_ticks);
      time_max    = SUM_W'({TIME_BITS{1'b1}});
      elapsed_sat = (sum > time_max) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
      step        = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;

      burst_ext = CAP_W'(burst_ff);
      token_max = CAP_W'({TOKEN_BITS{1'b1}});
      cap_ext   = (burst_ext < token_max) ? burst_ext : token_max;
      cap       = cap_ext[TOKEN_BITS-1:0];
      room      = cap - token_ff;
      quo_ext   = CMP_W'(quotient);
      room_ext  = CMP_W'(room);
      add       = (quo_ext < room_ext) ? quo_ext[TOKEN_BITS-1:0] : room;

      csr_hit = csr_write_enable &&
                (csr_index == CSR_UNLIMITED || csr_index == CSR_INTERVAL ||
                 csr_index == CSR_BURST);
   end

   always_comb begin
      unlimited_in = unlimited_ff;
      interval_in  = interval_ff;
      burst_in     = burst_ff;
      elapsed_in   = elapsed_ff;
      token_in     = token_ff;
      grant_in     = grant_ff;
      if (cmd.accept) begin
         elapsed_in = elapsed_sat;
         grant_in   = req_mode && unlimited_ff;
      end
      if (cmd.refill && quotient != '0) begin
         if (token_ff < cap) token_in = token_ff + add;
         elapsed_in = '0;
      end
      if (cmd.take && token_ff != '0) begin
         token_in = token_ff - TOKEN_BITS'(1);
         grant_in = 1'b1;
      end
      if (csr_hit) begin
         case (csr_index)
            CSR_UNLIMITED: unlimited_in = csr_write_data[0];
            CSR_INTERVAL:  interval_in  = csr_write_data[INTERVAL_W-1:0];
            CSR_BURST:     burst_in     = csr_write_data[BURST_W-1:0];
            default:       unlimited_in = unlimited_ff;
         endcase
         elapsed_in = '0;
         token_in   = '0;
      end
   end

   // The result register frees the input side while a finished word waits.
   always_comb begin
      token_out    = TOUT_W'(token_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unlimited_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         burst_ff     <= BURST_RESET;
         elapsed_ff   <= '0;
         token_ff     <= '0;
         grant_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unlimited_ff <= unlimited_in;
         interval_ff  <= interval_in;
         burst_ff     <= burst_in;
         elapsed_ff   <= elapsed_in;
         token_ff     <= token_in;
         grant_ff     <= grant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         rsp_granted_ff <= grant_ff;
         rsp_tokens_ff  <= token_out[TOKENS_OUT_W-1:0];
      end
   end

   assign status.unlimited = unlimited_ff;
   assign status.div_done  = div_done;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_tokens_left  = rsp_tokens_ff;

endmodule

### rtl/core/token_bucket_rate_limiter.sv
// Top level of the lazy-refill token bucket rate limiter.
//
//   channel  direction  handshake            contents
//   req      in         req_valid/req_ready  req_mode, req_ticks
//   rsp      out        rsp_valid/rsp_ready  rsp_granted, rsp_tokens_left
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// A time-only word or an unlimited request goes from accept straight to the result; a counted
// request runs the bit-serial divider that finds the whole intervals, then refill and take.
// Reset is synchronous and returns the bucket to empty and the registers to defaults.
// A finished word waits in the result register while the next request word is accepted.
`timescale 1ns / 1ps
module token_bucket_rate_limiter #(
   parameter int TIME_BITS  = tbrl_pkg::DEF_TIME_BITS,
   parameter int TOKEN_BITS = tbrl_pkg::DEF_TOKEN_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [tbrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbrl_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [tbrl_pkg::TICKS_W-1:0]      req_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_granted,
   output logic [tbrl_pkg::TOKENS_OUT_W-1:0] rsp_tokens_left
);
   import tbrl_pkg::*;

   cmd_type    cmd;
   status_type status;

   tbrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbrl_datapath #(
      .TIME_BITS  (TIME_BITS),
      .TOKEN_BITS (TOKEN_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mode         (req_mode),
      .req_ticks        (req_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_tokens_left  (rsp_tokens_left)
   );

endmodule

### rtl/core/tbrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
`timescale 1ns / 1ps
module tbrl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              csr_write_enable,
   input logic [tbrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [tbrl_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_granted,
   input logic [tbrl_pkg::TOKENS_OUT_W-1:0] rsp_tokens_left
);
   import tbrl_pkg::*;

   logic [1:0]         pending_ff, pending_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic               req_fire;
   logic               rsp_fire;

   always_comb begin
      req_fire   = req_valid && req_ready;
      rsp_fire   = rsp_valid && rsp_ready;
      pending_in = pending_ff + 2'(req_fire) - 2'(rsp_fire);
      burst_in   = burst_ff;
      if (csr_write_enable && csr_index == CSR_BURST) burst_in = csr_write_data[BURST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         burst_ff   <= BURST_RESET;
      end else begin
         pending_ff <= pending_in;
         burst_ff   <= burst_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_granted) && $stable(rsp_tokens_left))
      else $error("stalled result word changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result word shown with no request word outstanding");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two words outstanding");

   a_burst_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tokens_left <= burst_ff)
      else $error("token count above the burst limit");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_checker (.*);
